// ===== rtl/core/drc_pkg.sv =====
// Shared types and constants for the diagnostic response checker.
// Holds the item and result beat structs, status codes and register indexes.
// Depends on nothing.
package drc_pkg;

	// Result status codes
	typedef enum logic [2:0] {
		ST_POS    = 3'd0,
		ST_NEG    = 3'd1,
		ST_NOHDR  = 3'd2,
		ST_IDMIS  = 3'd3,
		ST_SIDMIS = 3'd4,
		ST_TRUNC  = 3'd5
	} status_t;

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_SID = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_RID = 1'd1;
	localparam int CFG_DATA_W = 16;

	localparam logic [7:0]  EXPECTED_SID_RST = 8'd80;
	localparam logic [15:0] EXPECTED_RID_RST = 16'd0;

	// Diagnostic-message marker 02 FD 80 01 and offsets from its first byte
	localparam logic [31:0] MARKER     = 32'h02FD_8001;
	localparam logic [7:0]  NEG_SID    = 8'h7F;
	localparam int          SID_OFFSET = 12;
	localparam int          MARK_LEN_M1 = 3;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       last_byte;
	} item_t;

	typedef struct packed {
		status_t    status;
		logic [7:0] neg_code;
		logic [7:0] seen_sid;
	} result_t;

endpackage

// ===== rtl/core/diag_response_checker.sv =====
// Diagnostic response checker: scans one received buffer a byte at a time
// and gives one verdict beat on the buffer's final byte.
// Depends on drc_pkg for beat structs, status codes and register indexes.
//
//   channel   direction  handshake              beat
//   item      in         item_valid/item_stall  drc_pkg::item_t (byte, final flag)
//   result    out        result_valid/stall     drc_pkg::result_t (status, code, sid)
//   cfg       in         cfg_valid/cfg_ready    cfg_index, cfg_data
//
// One byte a cycle unless item_stall is high: a byte beat is held in the input
// register, then the marker compare, the captures and the verdict run on it and
// land in the position/capture registers and the result register.
// A final byte's verdict passes through the input register, then the result register.
// Reset clears all per-buffer state and loads the register defaults.
// A stalled result register holds only a final byte; other bytes keep flowing
// until a final byte meets an occupied, stalled result register.
module diag_response_checker #(
	parameter int MAX_BUFFER_BYTES = 2048
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 item_valid,
	output logic                                 item_stall,
	input  drc_pkg::item_t                       item,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output drc_pkg::result_t                     result,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [drc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [drc_pkg::CFG_DATA_W-1:0]       cfg_data
);

	// Position counter must hold MAX_BUFFER_BYTES itself
	localparam int PW = $clog2(MAX_BUFFER_BYTES + 1);
	localparam logic [PW-1:0] MAX_POS  = PW'(MAX_BUFFER_BYTES);
	localparam logic [PW-1:0] MARK_M1  = PW'(drc_pkg::MARK_LEN_M1);
	localparam logic [PW:0]   SID_OFS  = (PW+1)'(drc_pkg::SID_OFFSET);

	// Configuration registers
	logic [7:0]  expected_sid_q;
	logic [15:0] expected_rid_q;

	// Input register
	logic            valid_s1;
	drc_pkg::item_t  item_s1;

	// Per-buffer state
	logic [23:0]   recent_q;
	logic [PW-1:0] pos_q;
	logic          found_q;
	logic [PW-1:0] mpos_q;
	logic [7:0]    svc_q;
	logic [7:0]    code_q;
	logic [7:0]    idlow_q;
	logic [1:0]    bas_q;

	// Result register
	logic             result_valid_q;
	drc_pkg::result_t result_q;

	// Next per-buffer state after the byte in the input register
	logic [31:0]   window;
	logic [23:0]   recent_nxt;
	logic [PW-1:0] pos_nxt;
	logic          found_nxt;
	logic [PW-1:0] mpos_nxt;
	logic [7:0]    svc_nxt;
	logic [7:0]    code_nxt;
	logic [7:0]    idlow_nxt;
	logic [1:0]    bas_nxt;
	logic [PW:0]   sid_pos;
	logic [PW:0]   sid_pos_nxt;

	logic             out_free;
	logic             s1_adv;
	logic             accept;
	drc_pkg::result_t verdict;

	// Handshake: a final byte only moves on when the result register can take it
	assign out_free   = !result_valid_q || !result_stall;
	assign s1_adv     = valid_s1 && (!item_s1.last_byte || out_free);
	assign item_stall = valid_s1 && !s1_adv;
	assign accept     = item_valid && !item_stall;
	assign cfg_ready  = 1'b1;

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Scan step: marker search, then service byte and the two captures after it
	assign window  = {recent_q, item_s1.rx_byte};
	assign sid_pos = {1'b0, mpos_q} + SID_OFS;

	always_comb begin
		recent_nxt = recent_q;
		pos_nxt    = pos_q;
		found_nxt  = found_q;
		mpos_nxt   = mpos_q;
		svc_nxt    = svc_q;
		code_nxt   = code_q;
		idlow_nxt  = idlow_q;
		bas_nxt    = bas_q;
		// Ignore bytes beyond the buffer limit
		if (pos_q < MAX_POS) begin
			if (!found_q) begin
				if (window == drc_pkg::MARKER && pos_q >= MARK_M1) begin
					found_nxt = 1'b1;
					mpos_nxt  = pos_q - MARK_M1;
				end
			end else if ({1'b0, pos_q} == sid_pos) begin
				svc_nxt = item_s1.rx_byte;
			end else if ({1'b0, pos_q} > sid_pos && bas_q != 2'd3) begin
				bas_nxt = bas_q + 2'd1;
				if (bas_nxt == 2'd2) begin
					code_nxt = item_s1.rx_byte;
				end else if (bas_nxt == 2'd3) begin
					idlow_nxt = item_s1.rx_byte;
				end
			end
			recent_nxt = window[23:0];
			pos_nxt    = pos_q + PW'(1);
		end
	end

	// Verdict on the updated state; used only for a final byte
	assign sid_pos_nxt = {1'b0, mpos_nxt} + SID_OFS;

	always_comb begin
		verdict.status   = drc_pkg::ST_NOHDR;
		verdict.neg_code = 8'd0;
		verdict.seen_sid = 8'd0;
		// Header missing: no marker, or the buffer ends before the service byte
		if (found_nxt && sid_pos_nxt < {1'b0, pos_nxt}) begin
			verdict.seen_sid = svc_nxt;
			if (svc_nxt == expected_sid_q) begin
				// Positive match has priority, even when the expected id is 7F
				if (expected_rid_q == 16'd0) begin
					verdict.status = drc_pkg::ST_POS;
				end else if (bas_nxt != 2'd3) begin
					verdict.status = drc_pkg::ST_TRUNC;
				end else if ({code_nxt, idlow_nxt} != expected_rid_q) begin
					verdict.status = drc_pkg::ST_IDMIS;
				end else begin
					verdict.status = drc_pkg::ST_POS;
				end
			end else if (svc_nxt == drc_pkg::NEG_SID) begin
				if (bas_nxt < 2'd2) begin
					verdict.status = drc_pkg::ST_TRUNC;
				end else begin
					// A zero code still reports as negative
					verdict.status   = drc_pkg::ST_NEG;
					verdict.neg_code = code_nxt;
				end
			end else begin
				verdict.status = drc_pkg::ST_SIDMIS;
			end
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_sid_q <= drc_pkg::EXPECTED_SID_RST;
			expected_rid_q <= drc_pkg::EXPECTED_RID_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				drc_pkg::CFG_EXPECTED_SID: expected_sid_q <= cfg_data[7:0];
				drc_pkg::CFG_EXPECTED_RID: expected_rid_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Input register: load on acceptance, drop once advanced
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	// Per-buffer state: advance on each byte, clear after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recent_q <= '0;
			pos_q    <= '0;
			found_q  <= 1'b0;
			mpos_q   <= '0;
			svc_q    <= '0;
			code_q   <= '0;
			idlow_q  <= '0;
			bas_q    <= '0;
		end else if (s1_adv) begin
			if (item_s1.last_byte) begin
				recent_q <= '0;
				pos_q    <= '0;
				found_q  <= 1'b0;
				mpos_q   <= '0;
				svc_q    <= '0;
				code_q   <= '0;
				idlow_q  <= '0;
				bas_q    <= '0;
			end else begin
				recent_q <= recent_nxt;
				pos_q    <= pos_nxt;
				found_q  <= found_nxt;
				mpos_q   <= mpos_nxt;
				svc_q    <= svc_nxt;
				code_q   <= code_nxt;
				idlow_q  <= idlow_nxt;
				bas_q    <= bas_nxt;
			end
		end
	end

	// Result register: hold while stalled, load a verdict on the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (s1_adv && item_s1.last_byte) begin
			result_valid_q <= 1'b1;
		end else if (out_free) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && item_s1.last_byte) begin
			result_q <= verdict;
		end
	end

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for diag_response_checker: directed buffers, then random ones.
// Predicts each random verdict beat from its own scan of the bytes and checks every field.
// Depends on drc_pkg and the diag_response_checker RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_BYTES   = 2048;
	localparam int HDR_MIN     = 8;      // marker must start this far before the end
	localparam int PHASE_ITEMS = 236;    // random bytes per register setting
	localparam int NUM_PHASES  = 7;
	localparam int HOLD_CYC    = 300;    // long receiver hold-off
	localparam int DRAIN_CYC   = 8;      // settle time after the last owed verdict is checked
	localparam int LIMIT_CYC   = 400000;

	// One row of the directed part; want is only meaningful where typed is set
	typedef struct {
		logic [7:0]        b;
		bit                last;
		bit                typed;
		drc_pkg::result_t  want;
	} step_t;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           item_valid;
	logic                           item_stall;
	drc_pkg::item_t                 item;
	logic                           result_valid;
	logic                           result_stall;
	drc_pkg::result_t               result;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [drc_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [drc_pkg::CFG_DATA_W-1:0] cfg_data;

	// Predictor copy of the registers and the per-buffer scan state
	logic [7:0]  want_sid;
	logic [15:0] want_rid;
	logic [23:0] tail3;
	int unsigned nbytes;
	bit          mark_seen;
	int unsigned mark_at;
	logic [7:0]  svc_cap;
	logic [7:0]  code_cap;
	logic [7:0]  idlo_cap;
	int unsigned past_svc;

	drc_pkg::result_t verdict_q[$];   // verdicts still owed by the block
	logic [7:0]       frame_q[$];     // bytes of the buffer about to be sent
	int               mismatches = 0;
	int               cycle_cnt = 0;
	bit               calm = 1'b0;    // neither side draws random gaps while set
	bit               hold_req = 1'b0;

	// Directed part: a lone byte after reset, a minimal positive buffer with the
	// service byte as its final byte, and a negative response cut off right
	// after its service byte.
	step_t steps[27] = '{
		'{8'hFF, 1'b1, 1'b1, '{drc_pkg::ST_NOHDR, 8'h00, 8'h00}},
		'{8'h02, 1'b0, 1'b0, '0}, '{8'hFD, 1'b0, 1'b0, '0},
		'{8'h80, 1'b0, 1'b0, '0}, '{8'h01, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0},
		'{8'h50, 1'b1, 1'b1, '{drc_pkg::ST_POS, 8'h00, 8'h50}},
		'{8'h02, 1'b0, 1'b0, '0}, '{8'hFD, 1'b0, 1'b0, '0},
		'{8'h80, 1'b0, 1'b0, '0}, '{8'h01, 1'b0, 1'b0, '0},
		'{8'hFF, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
		'{8'hFF, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
		'{8'hFF, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
		'{8'hFF, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
		'{8'h7F, 1'b1, 1'b1, '{drc_pkg::ST_TRUNC, 8'h00, 8'h7F}}
	};

	diag_response_checker #(
		.MAX_BUFFER_BYTES(MAX_BYTES)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Run limit
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == LIMIT_CYC) begin
			$display("[diag_response_checker] ERROR");
			$finish;
		end
	end

	// Drop everything the scan has gathered; a new buffer starts with the next byte
	task automatic clear_scan();
		tail3 = '0;
		nbytes = 0;
		mark_seen = 1'b0;
		mark_at = 0;
		svc_cap = '0;
		code_cap = '0;
		idlo_cap = '0;
		past_svc = 0;
	endtask

	// Add one byte to the end of the buffer being built
	task automatic append_byte(logic [7:0] b);
		frame_q = {frame_q, b};
	endtask

	// Advance the scan by one accepted byte; on the final byte queue the verdict
	task automatic scan_byte(drc_pkg::item_t it);
		logic [31:0]      win;
		drc_pkg::result_t v;
		// bytes past the buffer limit are ignored, though a final one still ends it
		if (nbytes < MAX_BYTES) begin
			win = {tail3, it.rx_byte};
			if (!mark_seen) begin
				// only the first marker counts
				if (win == drc_pkg::MARKER && nbytes >= drc_pkg::MARK_LEN_M1) begin
					mark_seen = 1'b1;
					mark_at = nbytes - drc_pkg::MARK_LEN_M1;
				end
			end else if (nbytes == mark_at + drc_pkg::SID_OFFSET) begin
				svc_cap = it.rx_byte;
			end else if (nbytes > mark_at + drc_pkg::SID_OFFSET && past_svc < 3) begin
				// service +2 is the negative code or routine id high, +3 the id low
				past_svc++;
				if (past_svc == 2)
					code_cap = it.rx_byte;
				else if (past_svc == 3)
					idlo_cap = it.rx_byte;
			end
			tail3 = win[23:0];
			nbytes++;
		end
		if (!it.last_byte)
			return;
		v.status = drc_pkg::ST_NOHDR;
		v.neg_code = '0;
		v.seen_sid = '0;
		if (mark_seen && mark_at + HDR_MIN <= nbytes &&
			mark_at + drc_pkg::SID_OFFSET < nbytes) begin
			v.seen_sid = svc_cap;
			// the positive match wins even when the expected service is 7F
			if (svc_cap == want_sid) begin
				if (want_rid == '0)
					v.status = drc_pkg::ST_POS;
				else if (past_svc < 3)
					v.status = drc_pkg::ST_TRUNC;
				else if ({code_cap, idlo_cap} != want_rid)
					v.status = drc_pkg::ST_IDMIS;
				else
					v.status = drc_pkg::ST_POS;
			end else if (svc_cap == drc_pkg::NEG_SID) begin
				// a code of zero is still a negative response
				if (past_svc < 2) begin
					v.status = drc_pkg::ST_TRUNC;
				end else begin
					v.status = drc_pkg::ST_NEG;
					v.neg_code = code_cap;
				end
			end else begin
				v.status = drc_pkg::ST_SIDMIS;
			end
		end
		verdict_q = {verdict_q, v};
		clear_scan();
	endtask

	// Offer one byte beat after a drawn gap; hold it until accepted. Valid stays
	// high straight into the next beat when no gap is drawn.
	task automatic send_byte(logic [7:0] b, bit last);
		int             gap;
		drc_pkg::item_t it;
		gap = calm ? 0 : $urandom_range(0, 6);
		it.rx_byte = b;
		it.last_byte = last;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (item_stall);
		scan_byte(it);
	endtask

	task automatic send_frame();
		foreach (frame_q[i])
			send_byte(frame_q[i], i == frame_q.size() - 1);
	endtask

	// Build one random buffer. Most are well formed around a marker with random
	// content; the rest are noise, near-miss markers or buffers cut short.
	task automatic build_frame();
		int         kind;
		int         tl;
		int         i;
		bit         rid_ok;
		logic [7:0] svc;
		logic [7:0] b;
		logic [7:0] mk[4];
		frame_q.delete();
		kind = $urandom_range(0, 99);
		if (kind < 10) begin
			repeat ($urandom_range(1, 24)) append_byte(8'($urandom));
			return;
		end
		if ($urandom_range(0, 2) == 0)
			repeat ($urandom_range(1, 6)) append_byte(8'($urandom));
		mk = '{drc_pkg::MARKER[31:24], drc_pkg::MARKER[23:16],
			drc_pkg::MARKER[15:8], drc_pkg::MARKER[7:0]};
		// near miss: flip one bit of the marker
		if (kind < 16)
			mk[$urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
		foreach (mk[j])
			append_byte(mk[j]);
		// cut short: the buffer ends somewhere before the service byte
		if (kind < 26) begin
			repeat ($urandom_range(0, drc_pkg::SID_OFFSET - 4)) append_byte(8'($urandom));
			return;
		end
		for (i = 0; i < drc_pkg::SID_OFFSET - 4; i++)
			append_byte(8'($urandom));
		// now and then a second marker in the gap, which must not take over
		if ($urandom_range(0, 7) == 0)
			for (i = 0; i < 4; i++)
				frame_q[frame_q.size() - 6 + i] = mk[i];
		case ($urandom_range(0, 9))
			0, 1, 2, 3: svc = want_sid;
			4, 5, 6:    svc = drc_pkg::NEG_SID;
			default:    svc = 8'($urandom);
		endcase
		append_byte(svc);
		// zero to three bytes after the service byte reach every truncation
		tl = $urandom_range(0, 4);
		if (tl == 4)
			tl = $urandom_range(4, 12);
		rid_ok = $urandom_range(0, 1);
		for (i = 0; i < tl; i++) begin
			b = 8'($urandom);
			if (i == 1 && rid_ok)
				b = want_rid[15:8];
			else if (i == 1 && svc == drc_pkg::NEG_SID && $urandom_range(0, 3) == 0)
				b = 8'h00;
			if (i == 2 && rid_ok)
				b = want_rid[7:0];
			append_byte(b);
		end
	endtask

	// Stop offering bytes and wait out every owed verdict, then the pipeline
	task automatic drain();
		item_valid <= 1'b0;
		while (verdict_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	// Write both registers back to back; valid stays high across the two beats
	task automatic program_regs(logic [7:0] sid, logic [15:0] rid);
		cfg_valid <= 1'b1;
		cfg_index <= drc_pkg::CFG_EXPECTED_SID;
		cfg_data <= {8'($urandom), sid};
		do @(posedge clk); while (!cfg_ready);
		want_sid = sid;
		cfg_index <= drc_pkg::CFG_EXPECTED_RID;
		cfg_data <= rid;
		do @(posedge clk); while (!cfg_ready);
		want_rid = rid;
		cfg_valid <= 1'b0;
	endtask

	// Byte source: reset, directed rows, then random buffers under each setting
	initial begin : byte_source
		int          ph;
		int          phase_bytes;
		logic [7:0]  sid_set[NUM_PHASES];
		logic [15:0] rid_set[NUM_PHASES];
		sid_set = '{drc_pkg::EXPECTED_SID_RST, 8'h00, 8'hFF, drc_pkg::NEG_SID,
			drc_pkg::NEG_SID, 8'($urandom), 8'h50};
		rid_set = '{drc_pkg::EXPECTED_RID_RST, 16'hFFFF, 16'h0001, 16'h0000, 16'hA55A,
			16'($urandom), 16'h0000};
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		want_sid = drc_pkg::EXPECTED_SID_RST;
		want_rid = drc_pkg::EXPECTED_RID_RST;
		clear_scan();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows; typed verdicts replace the predicted one
		foreach (steps[k]) begin
			send_byte(steps[k].b, steps[k].last);
			if (steps[k].typed)
				verdict_q[verdict_q.size() - 1] = steps[k].want;
		end

		for (ph = 0; ph < NUM_PHASES; ph++) begin
			// registers change only with the block idle
			if (ph > 0) begin
				drain();
				program_regs(sid_set[ph], rid_set[ph]);
			end
			phase_bytes = 0;
			if (ph == 2) begin
				// hold off the result side while short buffers keep coming, so
				// the result register fills and the byte side stalls
				calm = 1'b1;
				hold_req = 1'b1;
				repeat (12) begin
					frame_q.delete();
					repeat ($urandom_range(1, 2)) append_byte(8'($urandom));
					phase_bytes += frame_q.size();
					send_frame();
				end
			end
			while (phase_bytes < PHASE_ITEMS) begin
				calm = ($urandom_range(0, 4) == 0);
				build_frame();
				phase_bytes += frame_q.size();
				send_frame();
			end
		end

		drain();
		if (mismatches == 0)
			$display("[diag_response_checker] OK");
		else
			$display("[diag_response_checker] ERROR");
		$finish;
	end

	// Verdict sink: check each accepted beat against the oldest owed verdict.
	// Each beat waits a drawn number of cycles; a requested hold-off stalls
	// for a long stretch regardless.
	initial begin : verdict_sink
		int               wait_left;
		int               hold_left;
		drc_pkg::result_t exp_r;
		wait_left = 0;
		hold_left = 0;
		result_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (result_valid && !result_stall) begin
				if (verdict_q.size() == 0) begin
					$error("verdict beat with none owed: %p", result);
					mismatches++;
				end else begin
					exp_r = verdict_q.pop_front();
					if (result.status !== exp_r.status) begin
						$error("status: expected %0d, got %0d", exp_r.status, result.status);
						mismatches++;
					end
					if (result.neg_code !== exp_r.neg_code) begin
						$error("neg_code: expected %0h, got %0h", exp_r.neg_code, result.neg_code);
						mismatches++;
					end
					if (result.seen_sid !== exp_r.seen_sid) begin
						$error("seen_sid: expected %0h, got %0h", exp_r.seen_sid, result.seen_sid);
						mismatches++;
					end
				end
				wait_left = calm ? 0 : $urandom_range(0, 6);
			end else if (result_valid && wait_left > 0) begin
				wait_left--;
			end
			if (hold_req) begin
				hold_left = HOLD_CYC;
				hold_req = 1'b0;
			end else if (hold_left > 0) begin
				hold_left--;
			end
			result_stall <= (hold_left > 0) || (wait_left > 0);
		end
	end

endmodule
